// ===== rtl/aprs_compressed_position_encoder_macros.svh =====
// Assertion macros shared by the compressed position encoder RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef APRS_COMPRESSED_POSITION_ENCODER_MACROS_SVH
`define APRS_COMPRESSED_POSITION_ENCODER_MACROS_SVH

// same-cycle implication
`define ACPE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/acpe_pkg.sv =====
// Shared types, constants and tables of the compressed position encoder.
// No dependencies.
package acpe_pkg;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_SYM_TABLE = 1'b0;
    localparam logic REG_SYM_CODE  = 1'b1;

    localparam logic [6:0] SYM_TABLE_RST = 7'd47;
    localparam logic [6:0] SYM_CODE_RST  = 7'd62;

    localparam logic signed [27:0] LAT_LIM = 28'sd90000000;
    localparam logic signed [27:0] LAT_NEG = -28'sd90000000;
    localparam logic signed [28:0] LON_LIM = 29'sd180000000;
    localparam logic signed [28:0] LON_NEG = -29'sd180000000;
    localparam logic [28:0] LAT_OFS = 29'd90000000;
    localparam logic [29:0] LON_OFS = 30'd180000000;
    localparam logic [18:0] LAT_SCALE = 19'd380926;
    localparam logic [17:0] LON_SCALE = 18'd190463;
    localparam logic [8:0] HDG_MAX = 9'd359;

    localparam int PROD_W = 46;
    localparam int DIGITS = 4;
    localparam int SPD_MAX_CODE = 90;

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_OFS   = 8'd33;
    localparam logic [7:0] CH_TAIL  = 8'h5F;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef logic [DIGITS-1:0][6:0] dig_t;

    typedef struct packed {
        dig_t       lat_dig;
        dig_t       lon_dig;
        logic [6:0] course;
        logic [6:0] spd_code;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_MUL,
        FR_EST,
        FR_FIX,
        FR_DONE
    } front_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_SEND
    } back_state_t;

    typedef logic [127:0][16:0] spd_tab_t;

    // Divisor of digit k of the scaled product: 1e6 * 91^(3-k).
    function automatic logic [39:0] dig_div(input logic [1:0] k);
        logic [39:0] c;
        unique case (k)
            2'd0: c = 40'd753571000000;
            2'd1: c = 40'd8281000000;
            2'd2: c = 40'd91000000;
            2'd3: c = 40'd1000000;
        endcase
        return c;
    endfunction

    // Digit estimate from the top ten bits of the remainder; low by at most one.
    function automatic logic [6:0] dig_est(input logic [1:0] k, input logic [45:0] r);
        logic [9:0]  top;
        logic [9:0]  m;
        logic [19:0] p;
        unique case (k)
            2'd0:
            begin
                top = {1'b0, r[45:37]};
                m   = 10'd747;
            end
            2'd1:
            begin
                top = r[39:30];
                m   = 10'd531;
            end
            2'd2:
            begin
                top = r[33:24];
                m   = 10'd755;
            end
            2'd3:
            begin
                top = r[26:17];
                m   = 10'd536;
            end
        endcase
        p = {10'd0, top} * {10'd0, m};
        return p[18:12];
    endfunction

    // Minimum speed (1/16 mph) for each speed code; unused entries never match.
    function automatic spd_tab_t spd_thr_build();
        spd_tab_t    tab;
        logic [63:0] pw;
        logic [63:0] thr;
        logic [63:0] q;
        tab    = '1;
        tab[0] = '0;
        pw     = 64'd16777216;
        for (int n = 1; n <= SPD_MAX_CODE; n++)
        begin
            pw  = pw * 64'd27 / 64'd25;
            thr = (pw * 64'd15625 + 64'd16383) >> 14;
            if (thr <= 64'd16000000)
                q = 64'd0;
            else
                q = (thr - 64'd16000000 + 64'd868975) / 64'd868976;
            if (q > 64'd65536)
                q = 64'd65536;
            tab[n] = q[16:0];
        end
        return tab;
    endfunction

    localparam spd_tab_t SPD_THR = spd_thr_build();

endpackage

// ===== rtl/aprs_compressed_position_encoder.sv =====
// The byte sequencer sends one beat a cycle and so sets the rate of fixes;
// the front end is faster, and a two-entry job queue absorbs the difference.
// The receiver cannot stall; beats are dropped on no account and appear back to back.
// Reset (async, active low) empties the pipeline and sets the symbol bytes to '/' and '>'.
module aprs_compressed_position_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [27:0]            latitude_microdeg,
    input  logic signed [28:0]            longitude_microdeg,
    input  logic [8:0]                    heading_deg,
    input  logic [15:0]                   speed_mph_q4,
    output logic                          strobe,
    output logic [7:0]                    report_byte,
    output logic                          last_byte,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acpe_pkg::PADDR_W-1:0]  paddr,
    input  logic [acpe_pkg::PDATA_W-1:0]  pwdata,
    output logic [acpe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import acpe_pkg::*;

    logic [6:0] sym_table_reg, sym_table_next;
    logic [6:0] sym_code_reg, sym_code_next;
    logic       cfg_wr;
    logic       push, pop;
    job_t       f_job, q_job;
    q_stat_t    q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        sym_table_next = sym_table_reg;
        sym_code_next  = sym_code_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_SYM_TABLE: sym_table_next = pwdata[6:0];
                REG_SYM_CODE:  sym_code_next  = pwdata[6:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SYM_TABLE: prdata = {(PDATA_W - 7)'(0), sym_table_reg};
            REG_SYM_CODE:  prdata = {(PDATA_W - 7)'(0), sym_code_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_table_reg <= SYM_TABLE_RST;
            sym_code_reg  <= SYM_CODE_RST;
        end
        else
        begin
            sym_table_reg <= sym_table_next;
            sym_code_reg  <= sym_code_next;
        end
    end

    acpe_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .latitude_microdeg  (latitude_microdeg),
        .longitude_microdeg (longitude_microdeg),
        .heading_deg        (heading_deg),
        .speed_mph_q4       (speed_mph_q4),
        .q_stat             (q_stat),
        .push               (push),
        .job                (f_job)
    );

    acpe_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (f_job),
        .pop    (pop),
        .rd_job (q_job),
        .stat   (q_stat)
    );

    acpe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_job       (q_job),
        .q_stat      (q_stat),
        .pop         (pop),
        .sym_table   (sym_table_reg),
        .sym_code    (sym_code_reg),
        .strobe      (strobe),
        .report_byte (report_byte),
        .last_byte   (last_byte)
    );

endmodule

// ===== rtl/acpe_front.sv =====
// Front end: takes a fix, clamps it, scales it and splits it into base-91 digits.
// Also finds the speed code and the course. Depends on acpe_pkg and the assertion macros.
`include "aprs_compressed_position_encoder_macros.svh"

module acpe_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [27:0]  latitude_microdeg,
    input  logic signed [28:0]  longitude_microdeg,
    input  logic [8:0]          heading_deg,
    input  logic [15:0]         speed_mph_q4,
    input  acpe_pkg::q_stat_t   q_stat,
    output logic                push,
    output acpe_pkg::job_t      job
);
    import acpe_pkg::*;

    front_state_t state_reg, state_next;
    logic [1:0]   k_reg, k_next;
    logic         son_reg, son_next;
    logic [2:0]   sbit_reg, sbit_next;

    logic [27:0]  a_reg;
    logic [28:0]  b_reg;
    logic [45:0]  rl_reg, rg_reg;
    logic [6:0]   el_reg, eg_reg;
    dig_t         dl_reg, dg_reg;
    logic [6:0]   course_reg;
    logic [15:0]  q_reg;
    logic [6:0]   code_reg, code_next;

    logic                accept;
    logic signed [27:0]  lat_c;
    logic signed [28:0]  lon_c;
    logic [28:0]         lat_diff;
    logic [29:0]         lon_sum;
    logic [8:0]          hdg_sat;
    logic [45:0]         prod_l, prod_g;
    logic [39:0]         div_c;
    logic [45:0]         back_l, back_g, rem_l, rem_g, fix_l, fix_g;
    logic                ge_l, ge_g;
    logic [6:0]          dig_l, dig_g;
    logic [6:0]          bit_mask, cand;

    assign busy   = (state_reg != FR_IDLE) && !((state_reg == FR_DONE) && !q_stat.full);
    assign accept = start && !busy;
    assign push   = (state_reg == FR_DONE) && !q_stat.full;

    assign job.lat_dig  = dl_reg;
    assign job.lon_dig  = dg_reg;
    assign job.course   = course_reg;
    assign job.spd_code = code_reg;

    // input clamp and offset
    always_comb
    begin
        lat_c = latitude_microdeg;
        if (latitude_microdeg > LAT_LIM)
            lat_c = LAT_LIM;
        else if (latitude_microdeg < LAT_NEG)
            lat_c = LAT_NEG;
        lon_c = longitude_microdeg;
        if (longitude_microdeg > LON_LIM)
            lon_c = LON_LIM;
        else if (longitude_microdeg < LON_NEG)
            lon_c = LON_NEG;
        lat_diff = LAT_OFS - {lat_c[27], lat_c};
        lon_sum  = LON_OFS + {lon_c[28], lon_c};
        hdg_sat  = (heading_deg > HDG_MAX) ? HDG_MAX : heading_deg;
    end

    // scaling and digit correction
    always_comb
    begin
        prod_l = {18'd0, a_reg} * {27'd0, LAT_SCALE};
        prod_g = {17'd0, b_reg} * {28'd0, LON_SCALE};
        div_c  = dig_div(k_reg);
        back_l = {6'd0, div_c} * {39'd0, el_reg};
        back_g = {6'd0, div_c} * {39'd0, eg_reg};
        rem_l  = rl_reg - back_l;
        rem_g  = rg_reg - back_g;
        ge_l   = rem_l >= {6'd0, div_c};
        ge_g   = rem_g >= {6'd0, div_c};
        dig_l  = el_reg + {6'd0, ge_l};
        dig_g  = eg_reg + {6'd0, ge_g};
        fix_l  = ge_l ? rem_l - {6'd0, div_c} : rem_l;
        fix_g  = ge_g ? rem_g - {6'd0, div_c} : rem_g;
    end

    // speed code: binary search over the threshold table, one bit a cycle
    always_comb
    begin
        bit_mask  = 7'd1 << sbit_reg;
        cand      = code_reg | bit_mask;
        code_next = (SPD_THR[cand] <= {1'b0, q_reg}) ? cand : code_reg;
        son_next  = son_reg;
        sbit_next = sbit_reg;
        if (accept)
        begin
            son_next  = 1'b1;
            sbit_next = 3'd6;
        end
        else if (son_reg)
        begin
            if (sbit_reg == 3'd0)
                son_next = 1'b0;
            else
                sbit_next = sbit_reg - 3'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            FR_IDLE:
            begin
                if (accept)
                    state_next = FR_MUL;
            end
            FR_MUL:
            begin
                k_next     = 2'd0;
                state_next = FR_EST;
            end
            FR_EST:
            begin
                state_next = FR_FIX;
            end
            FR_FIX:
            begin
                if (k_reg == 2'(DIGITS - 1))
                    state_next = FR_DONE;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = FR_EST;
                end
            end
            FR_DONE:
            begin
                if (push)
                    state_next = accept ? FR_MUL : FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            k_reg     <= 2'd0;
            son_reg   <= 1'b0;
            sbit_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            son_reg   <= son_next;
            sbit_reg  <= sbit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg      <= lat_diff[27:0];
            b_reg      <= lon_sum[28:0];
            course_reg <= hdg_sat[8:2];
            q_reg      <= speed_mph_q4;
            code_reg   <= 7'd0;
        end
        else if (son_reg)
            code_reg <= code_next;

        if (state_reg == FR_MUL)
        begin
            rl_reg <= prod_l;
            rg_reg <= prod_g;
        end
        else if (state_reg == FR_FIX)
        begin
            rl_reg         <= fix_l;
            rg_reg         <= fix_g;
            dl_reg[k_reg]  <= dig_l;
            dg_reg[k_reg]  <= dig_g;
        end

        if (state_reg == FR_EST)
        begin
            el_reg <= dig_est(k_reg, rl_reg);
            eg_reg <= dig_est(k_reg, rg_reg);
        end
    end

    `ACPE_ASSERT_NOW(a_srch_done, state_reg == FR_DONE, !son_reg, "speed search still running")
    `ACPE_ASSERT_NOW(a_dig_range, state_reg == FR_FIX, (dig_l <= 7'd90) && (dig_g <= 7'd90), "digit above 90")
    `ACPE_ASSERT_NEXT(a_accept_mul, accept, state_reg == FR_MUL, "accepted fix not scaled")

endmodule

// ===== rtl/acpe_queue.sv =====
// Short job queue between the front end and the byte sequencer.
// Depends on acpe_pkg and the assertion macros.
`include "aprs_compressed_position_encoder_macros.svh"

module acpe_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  acpe_pkg::job_t     wr_job,
    input  logic               pop,
    output acpe_pkg::job_t     rd_job,
    output acpe_pkg::q_stat_t  stat
);
    import acpe_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, wp_next;
    logic [QPTR_W-1:0] rp_reg, rp_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == (QPTR_W + 1)'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rd_job     = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_job;
    end

    `ACPE_ASSERT_NOW(a_no_overrun, push, !stat.full, "push into full queue")
    `ACPE_ASSERT_NOW(a_no_underrun, pop, !stat.empty, "pop from empty queue")

endmodule

// ===== rtl/acpe_back.sv =====
// Byte sequencer: turns one queued job into the fourteen report beats.
// Depends on acpe_pkg and the assertion macros.
`include "aprs_compressed_position_encoder_macros.svh"

module acpe_back (
    input  logic               clk,
    input  logic               rst_n,
    input  acpe_pkg::job_t     q_job,
    input  acpe_pkg::q_stat_t  q_stat,
    output logic               pop,
    input  logic [6:0]         sym_table,
    input  logic [6:0]         sym_code,
    output logic               strobe,
    output logic [7:0]         report_byte,
    output logic               last_byte
);
    import acpe_pkg::*;

    localparam logic [3:0] POS_BANG  = 4'd0;
    localparam logic [3:0] POS_TABLE = 4'd1;
    localparam logic [3:0] POS_LAT0  = 4'd2;
    localparam logic [3:0] POS_LAT1  = 4'd3;
    localparam logic [3:0] POS_LAT2  = 4'd4;
    localparam logic [3:0] POS_LAT3  = 4'd5;
    localparam logic [3:0] POS_LON0  = 4'd6;
    localparam logic [3:0] POS_LON1  = 4'd7;
    localparam logic [3:0] POS_LON2  = 4'd8;
    localparam logic [3:0] POS_LON3  = 4'd9;
    localparam logic [3:0] POS_CODE  = 4'd10;
    localparam logic [3:0] POS_CRS   = 4'd11;
    localparam logic [3:0] POS_SPD   = 4'd12;
    localparam logic [3:0] POS_TAIL  = 4'd13;

    back_state_t state_reg, state_next;
    logic [3:0]  idx_reg, idx_next;
    job_t        job_reg, job_next;
    logic        strobe_reg, last_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_sel;

    assign strobe      = strobe_reg;
    assign last_byte   = last_reg;
    assign report_byte = byte_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        job_next   = job_reg;
        pop        = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    job_next   = q_job;
                    idx_next   = POS_BANG;
                    state_next = BK_SEND;
                end
            end
            BK_SEND:
            begin
                if (idx_reg == POS_TAIL)
                begin
                    if (!q_stat.empty)
                    begin
                        pop      = 1'b1;
                        job_next = q_job;
                        idx_next = POS_BANG;
                    end
                    else
                        state_next = BK_IDLE;
                end
                else
                    idx_next = idx_reg + 4'd1;
            end
        endcase
    end

    always_comb
    begin
        unique case (idx_reg)
            POS_BANG:  byte_sel = CH_BANG;
            POS_TABLE: byte_sel = {1'b0, sym_table};
            POS_LAT0:  byte_sel = {1'b0, job_reg.lat_dig[0]} + CH_OFS;
            POS_LAT1:  byte_sel = {1'b0, job_reg.lat_dig[1]} + CH_OFS;
            POS_LAT2:  byte_sel = {1'b0, job_reg.lat_dig[2]} + CH_OFS;
            POS_LAT3:  byte_sel = {1'b0, job_reg.lat_dig[3]} + CH_OFS;
            POS_LON0:  byte_sel = {1'b0, job_reg.lon_dig[0]} + CH_OFS;
            POS_LON1:  byte_sel = {1'b0, job_reg.lon_dig[1]} + CH_OFS;
            POS_LON2:  byte_sel = {1'b0, job_reg.lon_dig[2]} + CH_OFS;
            POS_LON3:  byte_sel = {1'b0, job_reg.lon_dig[3]} + CH_OFS;
            POS_CODE:  byte_sel = {1'b0, sym_code};
            POS_CRS:   byte_sel = {1'b0, job_reg.course} + CH_OFS;
            POS_SPD:   byte_sel = {1'b0, job_reg.spd_code} + CH_OFS;
            POS_TAIL:  byte_sel = CH_TAIL;
            default:   byte_sel = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            idx_reg    <= POS_BANG;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            strobe_reg <= (state_reg == BK_SEND);
            last_reg   <= (state_reg == BK_SEND) && (idx_reg == POS_TAIL);
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        byte_reg <= byte_sel;
    end

    `ACPE_ASSERT_NEXT(a_beats_packed, strobe_reg && !last_reg, strobe_reg, "gap inside a report")

endmodule
